// ----- sv/pwfb_pkg.sv -----
package pwfb_pkg;

  // Width of every sample, gradient and result field (signed Q8.8).
  localparam int unsigned SAMPLE_WIDTH = 16;
  // Largest window handled: two by two elements.
  localparam int unsigned MAX_LANES = 4;
  // Tie count width, enough to hold MAX_LANES.
  localparam int unsigned TIE_W = 3;
  // Gradient magnitude width: one bit more so that the most negative value fits.
  localparam int unsigned MAG_W = SAMPLE_WIDTH + 1;

  // Division of a magnitude by three as a multiply by a rounded-up reciprocal.
  localparam int unsigned DIV3_SHIFT = MAG_W + 2;
  localparam int unsigned RECIP_W = DIV3_SHIFT;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'(((1 << DIV3_SHIFT) + 2) / 3);

  localparam logic [TIE_W-1:0] TIES_TWO = TIE_W'(2);
  localparam logic [TIE_W-1:0] TIES_THREE = TIE_W'(3);
  localparam logic [TIE_W-1:0] TIES_FOUR = TIE_W'(4);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic {
    KIND_MAX = 1'b0,
    KIND_AVG = 1'b1
  } pool_kind_e;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_BWD = 1'b1
  } dir_e;

  typedef struct packed {
    logic    mode;
    sample_t sample_a;
    sample_t sample_b;
    sample_t sample_c;
    sample_t sample_d;
    sample_t grad_in;
  } in_item_t;

  typedef struct packed {
    sample_t pooled;
    sample_t grad_a;
    sample_t grad_b;
    sample_t grad_c;
    sample_t grad_d;
  } out_item_t;

  // Per-item control seen by every lane when it forms its gradient.
  typedef struct packed {
    logic bwd;
    logic avg;
  } lane_ctrl_t;

endpackage

// ----- sv/pwfb_merge.sv -----
// Combines the lane samples into the window maximum and the window sum.
module pwfb_merge import pwfb_pkg::*; #(
  parameter int unsigned NUM_LANES = 4,
  localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(NUM_LANES)
) (
  input  logic                    clk_i,
  input  sample_t                 samples_i [NUM_LANES],
  output sample_t                 max_o,
  output logic signed [SUM_W-1:0] sum_o
);

  sample_t                 max_d, max_q;
  logic signed [SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    max_d = samples_i[0];
    sum_d = SUM_W'(samples_i[0]);
    for (int i = 1; i < NUM_LANES; i++) begin
      if (samples_i[i] > max_d) begin
        max_d = samples_i[i];
      end
      sum_d = sum_d + SUM_W'(samples_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    sum_q <= sum_d;
  end

  assign max_o = max_q;
  assign sum_o = sum_q;

endmodule

// ----- sv/pwfb_grad_div.sv -----
// Divides the gradient magnitude by the tie count, or by the window size
// for average pooling, truncating toward zero, then restores the sign.
module pwfb_grad_div import pwfb_pkg::*; #(
  parameter int unsigned NUM_LANES = 4
) (
  input  logic                 clk_i,
  input  logic [NUM_LANES-1:0] hits_i,
  input  logic                 avg_i,
  input  mag_t                 mag_i,
  input  logic                 neg_i,
  output sample_t              quot_o
);

  localparam int unsigned AVG_SHIFT = $clog2(NUM_LANES);

  logic [TIE_W-1:0]         ties;
  logic [MAG_W+RECIP_W-1:0] prod;
  mag_t                     q_d, q_q;
  logic                     neg_q;
  mag_t                     signed_q;

  always_comb begin
    ties = TIE_W'($countones(hits_i));
    prod = (MAG_W + RECIP_W)'(mag_i) * (MAG_W + RECIP_W)'(DIV3_RECIP);
    if (avg_i) begin
      q_d = mag_i >> AVG_SHIFT;
    end else begin
      unique case (ties)
        TIES_TWO:   q_d = mag_i >> 1;
        TIES_THREE: q_d = prod[DIV3_SHIFT +: MAG_W];
        TIES_FOUR:  q_d = mag_i >> 2;
        default:    q_d = mag_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    neg_q <= neg_i;
  end

  assign signed_q = neg_q ? (~q_q + MAG_W'(1)) : q_q;
  assign quot_o   = sample_t'(signed_q[SAMPLE_WIDTH-1:0]);

endmodule

// ----- sv/pwfb_lane.sv -----
// One window element: flags whether it equals the window maximum and later
// picks its share of the gradient.
module pwfb_lane import pwfb_pkg::*; (
  input  logic       clk_i,
  input  sample_t    sample_i,
  input  sample_t    max_i,
  input  lane_ctrl_t ctrl_i,
  input  sample_t    quot_i,
  output logic       hit_o,
  output sample_t    grad_o
);

  sample_t sample_q;
  logic    hit_q;
  logic    hit_dly_q;
  sample_t grad_d, grad_q;

  always_comb begin
    if (ctrl_i.bwd && (ctrl_i.avg || hit_dly_q)) begin
      grad_d = quot_i;
    end else begin
      grad_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_i;
    hit_q     <= (sample_q == max_i);
    hit_dly_q <= hit_q;
    grad_q    <= grad_d;
  end

  assign hit_o  = hit_q;
  assign grad_o = grad_q;

endmodule

// ----- sv/pool2d_window_forward_backward_core.sv -----
// Pooling window core, forward and backward, signed Q8.8. One window can be
// accepted in every clock cycle: busy is never raised, so start alone
// decides when an item enters, and each result appears on res_item_o for
// one cycle with res_strobe_o high. The receiver cannot stall the core, and
// the four-stage pipeline (merge, lane compare, tie divide, lane select)
// keeps up with one item per cycle without holding anything back. The pool
// kind register is written through the configuration channel, which is
// always ready; a new kind is picked up by the next item accepted.
module pool2d_window_forward_backward_core import pwfb_pkg::*; #(
  parameter int unsigned POOL_SIDE = 2,
  localparam int unsigned NUM_LANES = POOL_SIDE * POOL_SIDE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  output logic      res_strobe_o,
  output out_item_t res_item_o
);

  localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(NUM_LANES);
  localparam int unsigned AVG_SHIFT = $clog2(NUM_LANES);

  // The pool kind register.
  pool_kind_e pool_kind_q;

  // Valid bit of each pipeline stage.
  logic [3:0] vld_d, vld_q;
  logic       accept;

  // Per-stage item control and payload.
  dir_e       mode1_q, mode2_q, mode3_q;
  pool_kind_e kind1_q, kind2_q, kind3_q;
  sample_t    grad1_q;
  sample_t    pooled2_d, pooled2_q, pooled3_q, pooled4_q;
  mag_t       grad_ext, mag2_d, mag2_q;
  logic       neg2_q;

  sample_t                 win [MAX_LANES];
  sample_t                 lane_samples [NUM_LANES];
  sample_t                 win_max;
  logic signed [SUM_W-1:0] win_sum;
  logic signed [SUM_W-1:0] win_mean;
  logic [NUM_LANES-1:0]    hits;
  sample_t                 quot;
  lane_ctrl_t              lane_ctrl;
  sample_t                 lane_grad [MAX_LANES];

  // Nothing ever blocks the pipeline, so the core is never busy and the
  // configuration channel always takes a write.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign vld_d       = {vld_q[2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_kind_q <= KIND_MAX;
      vld_q       <= '0;
    end else begin
      vld_q <= vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pool_kind_q <= pool_kind_e'(cfg_data_i);
      end
    end
  end

  // Window elements in row-major order; a one-element window uses only the
  // top-left sample.
  assign win[0] = in_item_i.sample_a;
  assign win[1] = in_item_i.sample_b;
  assign win[2] = in_item_i.sample_c;
  assign win[3] = in_item_i.sample_d;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_samples[i] = win[i];
    end
  end

  // Stage 1: the merge unit finds the window maximum and sum.
  pwfb_merge #(
    .NUM_LANES(NUM_LANES)
  ) u_merge (
    .clk_i    (clk_i),
    .samples_i(lane_samples),
    .max_o    (win_max),
    .sum_o    (win_sum)
  );

  // Stage 2: the forward value and the gradient magnitude. The mean is a
  // floor division, which the arithmetic shift gives directly.
  assign win_mean = win_sum >>> AVG_SHIFT;
  assign grad_ext = MAG_W'(grad1_q);
  assign mag2_d   = grad1_q[SAMPLE_WIDTH-1] ? (~grad_ext + MAG_W'(1)) : grad_ext;

  always_comb begin
    if (kind1_q == KIND_AVG) begin
      pooled2_d = sample_t'(win_mean[SAMPLE_WIDTH-1:0]);
    end else begin
      pooled2_d = win_max;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q   <= dir_e'(in_item_i.mode);
    kind1_q   <= pool_kind_q;
    grad1_q   <= in_item_i.grad_in;
    mode2_q   <= mode1_q;
    kind2_q   <= kind1_q;
    pooled2_q <= pooled2_d;
    mag2_q    <= mag2_d;
    neg2_q    <= grad1_q[SAMPLE_WIDTH-1];
    mode3_q   <= mode2_q;
    kind3_q   <= kind2_q;
    pooled3_q <= pooled2_q;
    pooled4_q <= pooled3_q;
  end

  // Stage 3: the gradient share, divided by the tie count from the lanes'
  // maximum flags or by the window size.
  pwfb_grad_div #(
    .NUM_LANES(NUM_LANES)
  ) u_grad_div (
    .clk_i (clk_i),
    .hits_i(hits),
    .avg_i (kind2_q == KIND_AVG),
    .mag_i (mag2_q),
    .neg_i (neg2_q),
    .quot_o(quot)
  );

  // Stage 4: in backward mode each lane keeps the share if the element took
  // part in the maximum, or if the window is averaged.
  assign lane_ctrl = '{bwd: (mode3_q == DIR_BWD), avg: (kind3_q == KIND_AVG)};

  for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
    if (g < NUM_LANES) begin : g_used
      pwfb_lane u_lane (
        .clk_i   (clk_i),
        .sample_i(lane_samples[g]),
        .max_i   (win_max),
        .ctrl_i  (lane_ctrl),
        .quot_i  (quot),
        .hit_o   (hits[g]),
        .grad_o  (lane_grad[g])
      );
    end else begin : g_unused
      // Elements outside a smaller window never receive a gradient.
      assign lane_grad[g] = '0;
    end
  end

  assign res_strobe_o       = vld_q[3];
  assign res_item_o.pooled  = pooled4_q;
  assign res_item_o.grad_a  = lane_grad[0];
  assign res_item_o.grad_b  = lane_grad[1];
  assign res_item_o.grad_c  = lane_grad[2];
  assign res_item_o.grad_d  = lane_grad[3];

endmodule

// ----- sim/tb.sv -----
module tb;
  import pwfb_pkg::*;

  // The core under test works on a two by two window.
  localparam int WIN_SIDE = 2;
  localparam int WIN_LANES = WIN_SIDE * WIN_SIDE;
  // Pipeline depth of the core, from the accepted item to its result.
  localparam int PIPE_DEPTH = 4;
  // A drain that takes this many cycles means results were lost.
  localparam int DRAIN_LIMIT = 200;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item_i = '0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;
  logic      res_strobe_o;
  out_item_t res_item_o;

  // Windows accepted by the core whose results have not come out yet, oldest
  // first. Each entry is the result that the window must produce.
  out_item_t  pending_windows[$];
  out_item_t  oldest_window;
  // The pool kind as the core should hold it, tracked from the write channel.
  pool_kind_e kind_model = KIND_MAX;
  int         mismatch_count = 0;
  int         result_count = 0;

  always #10 clk_i = ~clk_i;

  pool2d_window_forward_backward_core #(
    .POOL_SIDE(WIN_SIDE)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_strobe_o(res_strobe_o),
    .res_item_o  (res_item_o)
  );

  // Expected result of one window under the given pool kind. The samples are
  // widened to int so that the sum of four and the tie division are exact; the
  // result fields then keep the low sixteen bits.
  function automatic out_item_t pool_window(in_item_t it, pool_kind_e kind);
    int        s[MAX_LANES];
    int        peak;
    int        total;
    int        ties;
    int        grad;
    int        mean;
    int        share[MAX_LANES];
    out_item_t r;
    s[0] = it.sample_a;
    s[1] = it.sample_b;
    s[2] = it.sample_c;
    s[3] = it.sample_d;
    grad = it.grad_in;
    peak = s[0];
    total = 0;
    ties = 0;
    for (int i = 0; i < MAX_LANES; i++) begin
      share[i] = 0;
    end
    for (int i = 0; i < WIN_LANES; i++) begin
      if (s[i] > peak) begin
        peak = s[i];
      end
      total += s[i];
    end
    for (int i = 0; i < WIN_LANES; i++) begin
      if (s[i] == peak) begin
        ties++;
      end
    end
    // The mean rounds toward minus infinity, not toward zero.
    mean = total / WIN_LANES;
    if ((total % WIN_LANES) != 0 && total < 0) begin
      mean -= 1;
    end
    // Gradient shares truncate toward zero, which int division already does.
    if (it.mode == DIR_BWD) begin
      for (int i = 0; i < WIN_LANES; i++) begin
        if (kind == KIND_MAX) begin
          share[i] = (s[i] == peak) ? grad / ties : 0;
        end else begin
          share[i] = grad / WIN_LANES;
        end
      end
    end
    r.pooled = sample_t'((kind == KIND_MAX) ? peak : mean);
    r.grad_a = sample_t'(share[0]);
    r.grad_b = sample_t'(share[1]);
    r.grad_c = sample_t'(share[2]);
    r.grad_d = sample_t'(share[3]);
    return r;
  endfunction

  task automatic report_mismatch(string field, sample_t got, sample_t want);
    $display("result %0d: %s is %0d, expected %0d", result_count, field, got, want);
    mismatch_count++;
  endtask

  // Every result is checked against the oldest waiting window at the edge
  // that accepts it. An item accepted at the same edge joins the queue after
  // that, and a pool kind written at that edge only applies to later items.
  always @(posedge clk_i) begin
    if (res_strobe_o) begin
      if (pending_windows.size() == 0) begin
        $display("result %0d arrived with no window waiting", result_count);
        mismatch_count++;
      end else begin
        oldest_window = pending_windows.pop_front();
        if (res_item_o.pooled !== oldest_window.pooled) begin
          report_mismatch("pooled", res_item_o.pooled, oldest_window.pooled);
        end
        if (res_item_o.grad_a !== oldest_window.grad_a) begin
          report_mismatch("grad_a", res_item_o.grad_a, oldest_window.grad_a);
        end
        if (res_item_o.grad_b !== oldest_window.grad_b) begin
          report_mismatch("grad_b", res_item_o.grad_b, oldest_window.grad_b);
        end
        if (res_item_o.grad_c !== oldest_window.grad_c) begin
          report_mismatch("grad_c", res_item_o.grad_c, oldest_window.grad_c);
        end
        if (res_item_o.grad_d !== oldest_window.grad_d) begin
          report_mismatch("grad_d", res_item_o.grad_d, oldest_window.grad_d);
        end
      end
      result_count++;
    end
    if (rst_ni && start && !busy) begin
      pending_windows = {pending_windows, pool_window(in_item_i, kind_model)};
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      kind_model = pool_kind_e'(cfg_data_i);
    end
  end

  // Sends one item. The sender first idles for a random number of cycles up
  // to max_gap, then holds start until the core takes the item. Start is left
  // high afterwards so that back-to-back items stream without a bubble.
  task automatic send_window(in_item_t it, int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending and waits until every accepted window has produced its
  // result. First an edge passes with start low, so that the last accepted
  // window is surely queued before the queue is looked at. Windows still
  // waiting after the limit count as lost.
  task automatic drain_windows();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_windows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_windows.size() != 0) begin
      $display("%0d windows never produced a result", pending_windows.size());
      mismatch_count++;
      pending_windows.delete();
    end
  endtask

  // The pool kind only changes while the core is empty.
  task automatic write_pool_kind(pool_kind_e kind);
    drain_windows();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= kind;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_window(dir_e dir, sample_t a, sample_t b, sample_t c,
                                           sample_t d, sample_t g);
    in_item_t it;
    it.mode = dir;
    it.sample_a = a;
    it.sample_b = b;
    it.sample_c = c;
    it.sample_d = d;
    it.grad_in = g;
    return it;
  endfunction

  // Draws one sample. Style zero is uniform over the whole field, style one
  // stays near zero so that ties for the maximum are common, and style two
  // picks the edges of the range.
  function automatic sample_t draw_sample(int style);
    sample_t v;
    case (style)
      1: begin
        v = sample_t'(int'($urandom_range(0, 4)) - 2);
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = 16'sh0000;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      default: begin
        v = sample_t'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t random_window();
    int       style;
    int       grad_style;
    in_item_t it;
    style = $urandom_range(0, 3);
    grad_style = $urandom_range(0, 5);
    if (style == 3) begin
      it.sample_a = draw_sample($urandom_range(0, 2));
      it.sample_b = draw_sample($urandom_range(0, 2));
      it.sample_c = draw_sample($urandom_range(0, 2));
      it.sample_d = draw_sample($urandom_range(0, 2));
    end else begin
      it.sample_a = draw_sample(style);
      it.sample_b = draw_sample(style);
      it.sample_c = draw_sample(style);
      it.sample_d = draw_sample(style);
    end
    // Mostly uniform gradients, sometimes extreme ones, and zero now and then.
    if (grad_style == 5) begin
      it.grad_in = '0;
    end else begin
      it.grad_in = draw_sample((grad_style == 4) ? 2 : 0);
    end
    it.mode = $urandom_range(0, 1) ? DIR_BWD : DIR_FWD;
    return it;
  endfunction

  // Windows that hit the corners of both pool kinds: full-range extremes,
  // every tie count, zero gradient, truncation of small negative gradients,
  // floor of negative means, and alternating bit patterns.
  task automatic send_corner_windows();
    send_window(make_window(DIR_BWD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000), 1);
    send_window(make_window(DIR_BWD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff), 0);
    // Forward mode must leave every gradient at zero.
    send_window(make_window(DIR_FWD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh7fff), 0);
    send_window(make_window(DIR_BWD, -16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sh8000), 2);
    send_window(make_window(DIR_BWD, 16'sd300, -16'sd5, 16'sd300, 16'sd299, 16'sd1001), 0);
    // Three-way tie: under max pooling the gradient is divided by three.
    send_window(make_window(DIR_BWD, -16'sd257, -16'sd256, -16'sd256, -16'sd256,
                            16'sh8000), 0);
    send_window(make_window(DIR_BWD, 16'sh8000, 16'sd7, 16'sd7, 16'sd7, 16'sh7fff), 3);
    send_window(make_window(DIR_BWD, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0), 0);
    send_window(make_window(DIR_BWD, -16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd3), 0);
    send_window(make_window(DIR_BWD, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                            -16'sd1), 4);
    send_window(make_window(DIR_FWD, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                            16'sh5555), 0);
  endtask

  // Right after reset the core must pool by maximum without any write.
  task automatic test_reset_kind();
    send_window(make_window(DIR_FWD, -16'sd9, 16'sd4, 16'sd12, -16'sd3, 16'sd0), 0);
    send_window(make_window(DIR_BWD, 16'sd12, 16'sd4, 16'sd12, -16'sd3, -16'sd7), 0);
  endtask

  task automatic test_max_pool();
    write_pool_kind(KIND_MAX);
    send_corner_windows();
  endtask

  task automatic test_avg_pool();
    write_pool_kind(KIND_AVG);
    send_corner_windows();
  endtask

  // Long random streams under one kind, alternating between stretches that
  // run at full rate and stretches with random idle cycles.
  task automatic test_random_stream(pool_kind_e kind);
    write_pool_kind(kind);
    for (int burst = 0; burst < 6; burst++) begin
      for (int n = 0; n < 25; n++) begin
        send_window(random_window(), (burst % 2 == 0) ? 4 : 0);
      end
    end
  endtask

  // Short bursts with the kind flipped in between, so that the first items
  // after each write see the new kind.
  task automatic test_kind_switching();
    pool_kind_e kind;
    kind = KIND_AVG;
    for (int burst = 0; burst < 10; burst++) begin
      write_pool_kind(kind);
      for (int n = 0; n < 10; n++) begin
        send_window(random_window(), (burst % 3 == 0) ? 0 : 4);
      end
      kind = (kind == KIND_MAX) ? KIND_AVG : KIND_MAX;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_kind();
    test_max_pool();
    test_avg_pool();
    test_random_stream(KIND_MAX);
    test_random_stream(KIND_AVG);
    test_kind_switching();
    drain_windows();
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- pool2d_window_forward_backward_core.f -----
sv/pwfb_pkg.sv
sv/pwfb_merge.sv
sv/pwfb_grad_div.sv
sv/pwfb_lane.sv
sv/pool2d_window_forward_backward_core.sv
sim/tb.sv
